>>> sv/ihex_pkg.sv
// ----------------------------------------------------------------------------
// Intel HEX parser package
// Shared types, codes and character helpers for the record parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ihex_pkg;

   // Parser status codes as reported on the result channel.
   typedef enum logic [3:0] {
      STATUS_RUN      = 4'd0,
      STATUS_DONE     = 4'd1,
      STATUS_NOCOLON  = 4'd2,
      STATUS_HEX_LEN  = 4'd3,
      STATUS_HEX_ADDR = 4'd4,
      STATUS_HEX_TYPE = 4'd5,
      STATUS_HEX_DATA = 4'd6,
      STATUS_HEX_CSUM = 4'd7,
      STATUS_SUM      = 4'd8,
      STATUS_TYPE     = 4'd9
   } status_type;

   // Position within the current record.
   typedef enum logic [2:0] {
      PHASE_COLON,
      PHASE_LEN,
      PHASE_AHI,
      PHASE_ALO,
      PHASE_TYPE,
      PHASE_DATA,
      PHASE_CSUM_DATA,
      PHASE_CSUM_END
   } phase_type;

   // Record type codes that are supported.
   localparam logic [7:0] REC_DATA = 8'h00;
   localparam logic [7:0] REC_EOF  = 8'h01;

   localparam logic [7:0]  CHAR_COLON  = 8'h3A;
   localparam logic [16:0] NO_DATA_LOW = 17'h1FFFF;
   localparam logic [15:0] IGNORED_MAX = 16'hFFFF;

   // Decoded hex digit.
   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } nibble_type;

   // One result beat.
   typedef struct packed {
      logic        write_valid;
      logic [15:0] write_address;
      logic [7:0]  write_data;
      logic [3:0]  status;
      logic [16:0] lowest_address;
      logic [16:0] highest_address;
      logic [16:0] span_bytes;
      logic [15:0] ignored_count;
      logic        any_data;
   } result_type;

   // Hex digit decode: 0-9, A-F and a-f.
   function automatic nibble_type nibble_of(input logic [7:0] c);
      nibble_type n;
      n.valid = 1'b1;
      n.value = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         n.value = 4'(c - 8'h30);
      end else if (c inside {[8'h41:8'h46]}) begin
         n.value = 4'(c - 8'h37);
      end else if (c inside {[8'h61:8'h66]}) begin
         n.value = 4'(c - 8'h57);
      end else begin
         n.valid = 1'b0;
      end
      return n;
   endfunction

   // Space, tab, line feed, vertical tab, form feed and carriage return.
   function automatic logic is_blank(input logic [7:0] c);
      return (c inside {8'h20, [8'h09:8'h0D]});
   endfunction

   // Error code for a bad character in the field being read.
   function automatic status_type field_error(input phase_type phase);
      status_type s;
      case (phase)
         PHASE_LEN:            s = STATUS_HEX_LEN;
         PHASE_AHI, PHASE_ALO: s = STATUS_HEX_ADDR;
         PHASE_TYPE:           s = STATUS_HEX_TYPE;
         PHASE_DATA:           s = STATUS_HEX_DATA;
         default:              s = STATUS_HEX_CSUM;
      endcase
      return s;
   endfunction

endpackage

>>> sv/ihex_req_if.sv
// ----------------------------------------------------------------------------
// Intel HEX parser request channel
// Valid/ready channel carrying one text character per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ihex_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_char;
   logic       end_of_file;

   modport source (output valid, output text_char, output end_of_file, input ready);
   modport sink (input valid, input text_char, input end_of_file, output ready);
endinterface

>>> sv/ihex_rsp_if.sv
// ----------------------------------------------------------------------------
// Intel HEX parser response channel
// Valid/ready channel carrying one parse result per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ihex_rsp_if;
   logic        valid;
   logic        ready;
   logic        write_valid;
   logic [15:0] write_address;
   logic [7:0]  write_data;
   logic [3:0]  status;
   logic [16:0] lowest_address;
   logic [16:0] highest_address;
   logic [16:0] span_bytes;
   logic [15:0] ignored_count;
   logic        any_data;

   modport source (
      output valid, output write_valid, output write_address, output write_data,
      output status, output lowest_address, output highest_address,
      output span_bytes, output ignored_count, output any_data, input ready
   );
   modport sink (
      input valid, input write_valid, input write_address, input write_data,
      input status, input lowest_address, input highest_address,
      input span_bytes, input ignored_count, input any_data, output ready
   );
endinterface

>>> sv/ihex_csr_if.sv
// ----------------------------------------------------------------------------
// Intel HEX parser configuration channel
// Valid/ready write channel for the address offset register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ihex_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] address_offset;

   modport source (output valid, output address_offset, input ready);
   modport sink (input valid, input address_offset, output ready);
endinterface

>>> sv/ihex_parse_core.sv
// ----------------------------------------------------------------------------
// Intel HEX parser core
// Holds the record parse state and computes the result of each character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ihex_parse_core #(
   parameter int MEM_SIZE = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             text_char,
   input  logic                   end_of_file,
   input  logic [15:0]            address_offset,
   output ihex_pkg::result_type   result
);

   localparam logic [16:0] MemLimit = 17'(MEM_SIZE);

   ihex_pkg::phase_type  phase_ff, phase_in;
   ihex_pkg::status_type status_ff, status_in;
   logic        pending_ff, pending_in;
   logic [7:0]  acc_ff, acc_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  left_ff, left_in;
   logic [16:0] address_ff, address_in;
   logic [16:0] lowest_ff, lowest_in;
   logic [16:0] highest_ff, highest_in;
   logic [15:0] ignored_ff, ignored_in;

   ihex_pkg::nibble_type nib;
   logic [7:0]  full_byte;
   logic [7:0]  sum_add;
   logic [16:0] offset_ext;
   logic [16:0] addr_diff;
   logic        in_window;
   logic        seen;
   logic        wr_valid;
   logic [15:0] wr_address;
   logic [7:0]  wr_data;

   // Character decode and data window check.
   assign nib        = ihex_pkg::nibble_of(text_char);
   assign full_byte  = {acc_ff[3:0], nib.value};
   assign sum_add    = sum_ff + full_byte;
   assign offset_ext = {1'b0, address_offset};
   assign addr_diff  = address_ff - offset_ext;
   assign in_window  = (address_ff >= offset_ext) && (addr_diff < MemLimit);

   // Next parse state for the accepted character.
   always_comb begin
      phase_in   = phase_ff;
      status_in  = status_ff;
      pending_in = pending_ff;
      acc_in     = acc_ff;
      sum_in     = sum_ff;
      length_in  = length_ff;
      left_in    = left_ff;
      address_in = address_ff;
      lowest_in  = lowest_ff;
      highest_in = highest_ff;
      ignored_in = ignored_ff;
      wr_valid   = 1'b0;
      wr_address = 16'd0;
      wr_data    = 8'd0;
      if (step && status_ff == ihex_pkg::STATUS_RUN) begin
         if (phase_ff == ihex_pkg::PHASE_COLON) begin
            if (end_of_file) begin
               status_in = ihex_pkg::STATUS_DONE;
            end else if (text_char == ihex_pkg::CHAR_COLON) begin
               phase_in   = ihex_pkg::PHASE_LEN;
               pending_in = 1'b0;
               acc_in     = 8'd0;
               sum_in     = 8'd0;
            end else if (!ihex_pkg::is_blank(text_char)) begin
               status_in = ihex_pkg::STATUS_NOCOLON;
            end
         end else if (end_of_file || !nib.valid) begin
            status_in = ihex_pkg::field_error(phase_ff);
         end else if (!pending_ff) begin
            acc_in     = {4'd0, nib.value};
            pending_in = 1'b1;
         end else begin
            // A full byte is complete.
            acc_in     = full_byte;
            pending_in = 1'b0;
            sum_in     = sum_add;
            case (phase_ff)
               ihex_pkg::PHASE_LEN: begin
                  length_in = full_byte;
                  phase_in  = ihex_pkg::PHASE_AHI;
               end
               ihex_pkg::PHASE_AHI: begin
                  address_in = {1'b0, full_byte, 8'd0};
                  phase_in   = ihex_pkg::PHASE_ALO;
               end
               ihex_pkg::PHASE_ALO: begin
                  address_in = {address_ff[16:8], full_byte};
                  phase_in   = ihex_pkg::PHASE_TYPE;
               end
               ihex_pkg::PHASE_TYPE: begin
                  if (full_byte == ihex_pkg::REC_DATA) begin
                     left_in  = length_ff;
                     phase_in = (length_ff != 8'd0) ? ihex_pkg::PHASE_DATA
                                                    : ihex_pkg::PHASE_CSUM_DATA;
                  end else if (full_byte == ihex_pkg::REC_EOF) begin
                     phase_in = ihex_pkg::PHASE_CSUM_END;
                  end else begin
                     status_in = ihex_pkg::STATUS_TYPE;
                  end
               end
               ihex_pkg::PHASE_DATA: begin
                  if (in_window) begin
                     wr_valid   = 1'b1;
                     wr_address = addr_diff[15:0];
                     wr_data    = full_byte;
                  end else if (ignored_ff != ihex_pkg::IGNORED_MAX) begin
                     ignored_in = ignored_ff + 16'd1;
                  end
                  if (address_ff > highest_ff) begin
                     highest_in = address_ff;
                  end
                  if (address_ff < lowest_ff) begin
                     lowest_in = address_ff;
                  end
                  address_in = address_ff + 17'd1;
                  left_in    = left_ff - 8'd1;
                  if (left_ff == 8'd1) begin
                     phase_in = ihex_pkg::PHASE_CSUM_DATA;
                  end
               end
               ihex_pkg::PHASE_CSUM_DATA: begin
                  if (sum_add != 8'd0) begin
                     status_in = ihex_pkg::STATUS_SUM;
                  end else begin
                     phase_in = ihex_pkg::PHASE_COLON;
                  end
               end
               default: begin
                  status_in = (sum_add != 8'd0) ? ihex_pkg::STATUS_SUM
                                                : ihex_pkg::STATUS_DONE;
               end
            endcase
         end
      end
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= ihex_pkg::PHASE_COLON;
         status_ff  <= ihex_pkg::STATUS_RUN;
         pending_ff <= 1'b0;
         acc_ff     <= 8'd0;
         sum_ff     <= 8'd0;
         length_ff  <= 8'd0;
         left_ff    <= 8'd0;
         address_ff <= 17'd0;
         lowest_ff  <= ihex_pkg::NO_DATA_LOW;
         highest_ff <= 17'd0;
         ignored_ff <= 16'd0;
      end else begin
         phase_ff   <= phase_in;
         status_ff  <= status_in;
         pending_ff <= pending_in;
         acc_ff     <= acc_in;
         sum_ff     <= sum_in;
         length_ff  <= length_in;
         left_ff    <= left_in;
         address_ff <= address_in;
         lowest_ff  <= lowest_in;
         highest_ff <= highest_in;
         ignored_ff <= ignored_in;
      end
   end

   // Result of this character, taken from the updated state.
   assign seen = (lowest_in != ihex_pkg::NO_DATA_LOW);

   always_comb begin
      result.write_valid     = wr_valid;
      result.write_address   = wr_address;
      result.write_data      = wr_data;
      result.status          = status_in;
      result.lowest_address  = seen ? lowest_in : 17'd0;
      result.highest_address = seen ? highest_in : 17'd0;
      result.span_bytes      = seen ? (highest_in - lowest_in + 17'd1) : 17'd0;
      result.ignored_count   = ignored_in;
      result.any_data        = seen;
   end

endmodule

>>> sv/intel_hex_record_parser_top.sv
// ----------------------------------------------------------------------------
// Intel HEX record parser
// The result of a character is registered and appears in the cycle after its beat is taken.
// Throughput: one character per cycle; a full output register stalls input
// only while the result side is not ready.
// Reset: parser waits for a colon, status running, offset zero, no data seen.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module intel_hex_record_parser_top #(
   parameter int MEM_SIZE = 65536
) (
   input  logic        clock,
   input  logic        reset,
   ihex_req_if.sink    req_chan,
   ihex_rsp_if.source  rsp_chan,
   ihex_csr_if.sink    csr_chan
);

   localparam logic [16:0] MemLimit = 17'(MEM_SIZE);

   logic                 rsp_valid_ff, rsp_valid_in;
   ihex_pkg::result_type result_ff, result_in;
   logic [15:0]          offset_ff;
   logic                 load;

   // Configuration register, always ready.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= 16'd0;
      end else if (csr_chan.valid) begin
         offset_ff <= csr_chan.address_offset;
      end
   end

   // A new beat enters whenever the output register is empty or draining.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign load           = req_chan.valid && req_chan.ready;

   ihex_parse_core #(
      .MEM_SIZE (MEM_SIZE)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (load),
      .text_char      (req_chan.text_char),
      .end_of_file    (req_chan.end_of_file),
      .address_offset (offset_ff),
      .result         (result_in)
   );

   // Output register.
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.write_valid     = result_ff.write_valid;
   assign rsp_chan.write_address   = result_ff.write_address;
   assign rsp_chan.write_data      = result_ff.write_data;
   assign rsp_chan.status          = result_ff.status;
   assign rsp_chan.lowest_address  = result_ff.lowest_address;
   assign rsp_chan.highest_address = result_ff.highest_address;
   assign rsp_chan.span_bytes      = result_ff.span_bytes;
   assign rsp_chan.ignored_count   = result_ff.ignored_count;
   assign rsp_chan.any_data        = result_ff.any_data;

`ifndef SYNTHESIS
   // A held result blocks new beats.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("input taken while result is stalled");

   // Once finished or failed, the status never changes.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.status != ihex_pkg::STATUS_RUN && load)
      |=> (result_ff.status == $past(result_ff.status)))
      else $error("terminal status changed");

   // Writes stay inside the memory window.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.write_valid)
      |-> ({1'b0, result_ff.write_address} < MemLimit))
      else $error("write address beyond memory size");

   // Address range is ordered once data has been seen.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.any_data)
      |-> (result_ff.lowest_address <= result_ff.highest_address))
      else $error("lowest address above highest address");
`endif

endmodule
